// ===== design/ptd_pkg.sv =====
// Shared types and constants for the trial-division primality tester.
package ptd_pkg;

	localparam int PTD_VALUE_BITS = 31;

	// Candidate divisors run d, d + PAIR_OFFSET for d = FIRST_DIVISOR, + STEP, ...
	localparam int SMALL_DIVISOR = 3;
	localparam int FIRST_DIVISOR = 5;
	localparam int PAIR_OFFSET   = 2;
	localparam int DIVISOR_STEP  = 6;

	typedef enum logic [1:0] {
		SEL_THREE,
		SEL_D,
		SEL_D2
	} ptd_div_sel_t;

	typedef struct packed {
		logic         load;       // capture the input value
		logic         div_start;  // launch one division of n
		ptd_div_sel_t div_sel;
		logic         d_init;     // d <= first divisor
		logic         d_step;     // d <= d + step
	} ptd_cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic n_is23;
		logic n_even;
		logic div_done;
		logic rem_zero;
		logic quot_lt_d;          // d > n / d: no divisor left to try
	} ptd_sts_t;

endpackage

// ===== design/ptd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ptd_div #(
	parameter int VALUE_BITS = ptd_pkg::PTD_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [VALUE_BITS-1:0] remainder
);
	import ptd_pkg::*;

	localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] dvs_q;

	logic [VALUE_BITS:0]   rem_shift;
	logic [VALUE_BITS:0]   rem_diff;
	logic                  fits;

	assign rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};
	assign fits      = (rem_shift >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_diff[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/ptd_datapath.sv =====
// Datapath: value under test, candidate divisor and the shared divider.
module ptd_datapath #(
	parameter int VALUE_BITS = ptd_pkg::PTD_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  ptd_pkg::ptd_cmd_t     cmd,
	output ptd_pkg::ptd_sts_t     sts
);
	import ptd_pkg::*;

	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] divisor;
	logic [VALUE_BITS-1:0] quotient;
	logic [VALUE_BITS-1:0] remainder;
	logic                  div_done;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= value;
		end
		if (cmd.d_init) begin
			d_q <= VALUE_BITS'(FIRST_DIVISOR);
		end else if (cmd.d_step) begin
			d_q <= d_q + VALUE_BITS'(DIVISOR_STEP);
		end
	end

	always_comb begin
		case (cmd.div_sel)
			SEL_THREE: divisor = VALUE_BITS'(SMALL_DIVISOR);
			SEL_D:     divisor = d_q;
			SEL_D2:    divisor = d_q + VALUE_BITS'(PAIR_OFFSET);
			default:   divisor = d_q;
		endcase
	end

	ptd_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (n_q),
		.divisor   (divisor),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	always_comb begin
		sts.n_lt2     = (n_q[VALUE_BITS-1:1] == '0);
		sts.n_is23    = (n_q[VALUE_BITS-1:2] == '0) && n_q[1];
		sts.n_even    = !n_q[0];
		sts.div_done  = div_done;
		sts.rem_zero  = (remainder == '0);
		sts.quot_lt_d = (d_q > quotient);
	end

endmodule

// ===== design/ptd_ctrl.sv =====
// Controller: sequences the small-value checks and the trial-division loop.
module ptd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ptd_pkg::ptd_sts_t sts,
	output ptd_pkg::ptd_cmd_t cmd,
	output logic              busy,
	output logic              done,
	output logic              prime
);
	import ptd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WAIT3,
		ST_DIVD,
		ST_WAITD,
		ST_WAITD2
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   prime_q;

	always_comb begin
		cmd = '0;
		cmd.div_sel = SEL_THREE;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_CHECK: begin
				cmd.div_start = !(sts.n_lt2 || sts.n_is23 || sts.n_even);
				cmd.div_sel   = SEL_THREE;
			end
			ST_WAIT3: begin
				cmd.d_init = sts.div_done && !sts.rem_zero;
			end
			ST_DIVD: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_D;
			end
			ST_WAITD: begin
				cmd.div_start = sts.div_done && !sts.quot_lt_d && !sts.rem_zero;
				cmd.div_sel   = SEL_D2;
			end
			ST_WAITD2: begin
				cmd.d_step = sts.div_done && !sts.rem_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.n_lt2 || sts.n_is23 || sts.n_even) begin
						// 2 and 3 prime; 0, 1 and other evens not
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						prime_q <= sts.n_is23;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT3;
					end
				end
				ST_WAIT3: begin
					if (sts.div_done) begin
						if (sts.rem_zero) begin
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
							prime_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIVD;
						end
					end
				end
				ST_DIVD: begin
					state_q <= ST_WAITD;
				end
				ST_WAITD: begin
					if (sts.div_done) begin
						if (sts.quot_lt_d || sts.rem_zero) begin
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
							prime_q <= sts.quot_lt_d;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WAITD2;
						end
					end
				end
				ST_WAITD2: begin
					if (sts.div_done) begin
						if (sts.rem_zero) begin
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
							prime_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIVD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign prime = prime_q;

endmodule

// ===== design/prime_test_trial_division.sv =====
// Top level of the trial-division primality tester.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------
//   input    | start, busy        | value [VALUE_BITS-1:0]
//   result   | done (1-cycle)     | prime
//
// Values 0..3 and even values are decided in the check state, with no division. An
// odd value costs one division by 3, then per candidate d = 5, 11, ... a launch
// state and two divisions, by d and by d + 2, until d*d > value or a remainder of
// zero ends the search.
// Reset clears the controller and divider control; nothing else to clear.
// busy is high from the accepted item until its done strobe; busy is already low
// in the done cycle, so the next item can be accepted at the edge that ends it.
// The receiver cannot stall.
module prime_test_trial_division #(
	parameter int VALUE_BITS = ptd_pkg::PTD_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  busy,
	output logic                  done,
	output logic                  prime
);
	import ptd_pkg::*;

	ptd_cmd_t cmd;
	ptd_sts_t sts;

	ptd_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.cmd    (cmd),
		.sts    (sts)
	);

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.prime    (prime)
	);

	// Result strobe always closes the busy window.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> busy)
		else $error("divider launched while idle");

endmodule

// ===== bench/tb_prime_test_trial_division.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the trial-division primality tester.
module tb_prime_test_trial_division;

	localparam int VB = ptd_pkg::PTD_VALUE_BITS;
	localparam longint unsigned VALUE_MASK = (64'd1 << VB) - 1;
	localparam int unsigned STALL_LIMIT = 2_000_000;

	typedef struct {
		longint unsigned value;
		bit              verdict;
	} verdict_t;

	class primality_board;
		verdict_t    pending_verdicts[$];
		int unsigned mismatches = 0;

		static function bit trial_division_verdict(longint unsigned n);
			longint unsigned d;
			if (n < 2) return 1'b0;
			if (n == 2 || n == ptd_pkg::SMALL_DIVISOR) return 1'b1;
			if (n % 2 == 0 || n % ptd_pkg::SMALL_DIVISOR == 0) return 1'b0;
			// d <= n / d keeps the bound exact at the top of the range
			for (d = ptd_pkg::FIRST_DIVISOR; d <= n / d; d += ptd_pkg::DIVISOR_STEP) begin
				if (n % d == 0 || n % (d + ptd_pkg::PAIR_OFFSET) == 0) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_value(longint unsigned v);
			verdict_t item;
			item.value   = v & VALUE_MASK;
			item.verdict = trial_division_verdict(item.value);
			pending_verdicts.push_back(item);
		endfunction

		function void check_verdict(bit got);
			verdict_t item;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result: expected none, got prime %0b", $time, got);
				mismatches++;
				return;
			end
			item = pending_verdicts.pop_front();
			if (got !== item.verdict) begin
				$display("%0t: prime mismatch for value %0d: expected %0b, got %0b",
					$time, item.value, item.verdict, got);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [VB-1:0] value = '0;
	logic          busy;
	logic          done;
	logic          prime;

	primality_board board = new();
	int unsigned    quiet_cycles = 0;

	prime_test_trial_division #(.VALUE_BITS(VB)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (value),
		.busy    (busy),
		.done    (done),
		.prime   (prime)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_verdict(prime);
	end

	// Ends the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved in %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_value(longint unsigned v, int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v[VB-1:0];
		do @(posedge clk); while (busy);
		board.note_value(v);
	endtask

	// Mostly small values; full-range values carry a small factor so they stay fast.
	function automatic longint unsigned pick_value();
		int unsigned     factor_pool[12] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43};
		longint unsigned r;
		int unsigned     p;
		r = longint'($urandom) & VALUE_MASK;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(4095);
			4, 5:       return $urandom_range(262143);
			6:          return r & ~64'd1;
			7:          return r - r % ptd_pkg::SMALL_DIVISOR;
			default: begin
				p = factor_pool[$urandom_range(11)];
				return p * longint'($urandom_range(int'(VALUE_MASK / p), 1));
			end
		endcase
	endfunction

	initial begin
		longint unsigned directed[] = '{
			0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 35, 49, 121, 143, 169, 289, 65537,
			1018081, 1022117, 64'h4000_0000, 64'h5555_5555, 64'h2AAA_AAAA,
			VALUE_MASK - 4, VALUE_MASK - 2, VALUE_MASK - 1, VALUE_MASK
		};
		int unsigned idle_by_phase[4] = '{0, 54, 0, 18};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_value(directed[i], 0);
		foreach (idle_by_phase[ph]) begin
			repeat (25)
				send_value(pick_value(), idle_by_phase[ph]);
		end
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
